FILE: rtl/core/wpa_pkg.sv
// Shared types, constants and controller/datapath interface for the windowed peak alarm.
package wpa_pkg;

   localparam int DEPTH_DEFAULT = 64;

   localparam int TIME_W      = 32;
   localparam int VALUE_W     = 16;
   localparam int CFG_W       = 16;
   localparam int COUNT_OUT_W = 7;
   localparam int CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] REG_WINDOW_LENGTH   = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_ALARM_THRESHOLD = CSR_INDEX_W'(1);

   localparam logic [CFG_W-1:0] WINDOW_LENGTH_RESET   = CFG_W'(60);
   localparam logic [CFG_W-1:0] ALARM_THRESHOLD_RESET = CFG_W'(200);

   typedef struct packed {
      logic [TIME_W-1:0]  sample_time;
      logic [VALUE_W-1:0] sample_value;
   } wpa_req_type;

   typedef struct packed {
      logic [VALUE_W-1:0]     window_peak;
      logic                   alarm;
      logic [COUNT_OUT_W-1:0] candidate_count;
      logic                   overflow;
   } wpa_rsp_type;

   typedef struct packed {
      logic load;
      logic drop_front;
      logic start_prune;
      logic drop_back;
      logic append;
      logic finish;
   } wpa_cmd_type;

   typedef struct packed {
      logic count_zero;
      logic count_last;
      logic count_full;
      logic expired;
      logic dominated;
      logic out_free;
   } wpa_status_type;

endpackage

FILE: rtl/core/wpa_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module wpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/wpa_ctrl.sv
// Controller state machine that sequences expire, prune, append and result delivery.
module wpa_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  wpa_pkg::wpa_status_type status,
   output wpa_pkg::wpa_cmd_type    cmd
);

   import wpa_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_EXPIRE = 5'b00010,
      ST_PRUNE  = 5'b00100,
      ST_APPEND = 5'b01000,
      ST_FINISH = 5'b10000
   } wpa_state_type;

   wpa_state_type state_ff;
   wpa_state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = status.count_zero ? ST_APPEND : ST_EXPIRE;
            end
         end
         ST_EXPIRE: begin
            if (status.expired) begin
               cmd.drop_front = 1'b1;
               if (status.count_last) begin
                  state_in = ST_APPEND;
               end
            end else begin
               cmd.start_prune = 1'b1;
               state_in        = ST_PRUNE;
            end
         end
         ST_PRUNE: begin
            if (status.dominated) begin
               cmd.drop_back = 1'b1;
               if (status.count_last) begin
                  state_in = ST_APPEND;
               end
            end else begin
               state_in = ST_APPEND;
            end
         end
         ST_APPEND: begin
            cmd.append = 1'b1;
            state_in   = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

FILE: rtl/core/wpa_datapath.sv
// Datapath holding the candidate memory, queue pointers, configuration and result register.
module wpa_datapath #(
   parameter int DEPTH = wpa_pkg::DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  wpa_pkg::wpa_cmd_type                cmd,
   output wpa_pkg::wpa_status_type             status,
   input  wpa_pkg::wpa_req_type                req_data,
   input  logic                                csr_write_enable,
   input  logic [wpa_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [wpa_pkg::CFG_W-1:0]           csr_write_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output wpa_pkg::wpa_rsp_type                rsp_data
);

   import wpa_pkg::*;

   localparam int PTR_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int SUM_W  = CNT_W + 1;
   localparam int DATA_W = TIME_W + VALUE_W;

   function automatic logic [PTR_W-1:0] wrap(input logic [PTR_W-1:0] base,
                                             input logic [CNT_W-1:0] offset);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(base) + SUM_W'(offset);
      if (sum >= SUM_W'(DEPTH)) begin
         sum = sum - SUM_W'(DEPTH);
      end
      return sum[PTR_W-1:0];
   endfunction

   logic [PTR_W-1:0]   head_ff, head_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [TIME_W-1:0]  now_ff;
   logic [VALUE_W-1:0] value_ff;
   logic [VALUE_W-1:0] front_ff;
   logic               from_sample_ff;
   logic               from_ram_ff;
   logic               ovf_ff;
   logic [CFG_W-1:0]   window_ff;
   logic [CFG_W-1:0]   threshold_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   wpa_rsp_type        rsp_data_ff;

   logic               ram_wr_en;
   logic [PTR_W-1:0]   ram_wr_addr;
   logic [DATA_W-1:0]  ram_wr_data;
   logic               ram_rd_en;
   logic               ram_rd_back;
   logic [PTR_W-1:0]   ram_rd_addr;
   logic [DATA_W-1:0]  ram_rd_data;
   logic [TIME_W-1:0]  rd_time;
   logic [VALUE_W-1:0] rd_value;
   logic [TIME_W-1:0]  age;
   logic [VALUE_W-1:0] peak;
   logic [CNT_W+COUNT_OUT_W-1:0] count_ext;

   assign rd_time  = ram_rd_data[DATA_W-1:VALUE_W];
   assign rd_value = ram_rd_data[VALUE_W-1:0];
   assign age      = now_ff - rd_time;

   assign status.count_zero = (count_ff == '0);
   assign status.count_last = (count_ff == CNT_W'(1));
   assign status.count_full = (count_ff == CNT_W'(DEPTH));
   assign status.expired    = (age >= TIME_W'(window_ff));
   assign status.dominated  = (rd_value <= value_ff);
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (cmd.drop_front) begin
         head_in  = wrap(head_ff, CNT_W'(1));
         count_in = count_ff - CNT_W'(1);
      end
      if (cmd.drop_back) begin
         count_in = count_ff - CNT_W'(1);
      end
      if (cmd.append) begin
         if (status.count_full) begin
            head_in = wrap(head_ff, CNT_W'(1));
         end else begin
            count_in = count_ff + CNT_W'(1);
         end
      end
   end

   assign ram_wr_en   = cmd.append;
   assign ram_wr_addr = wrap(head_ff, count_ff);
   assign ram_wr_data = {now_ff, value_ff};

   assign ram_rd_en = cmd.load || cmd.start_prune
                   || ((cmd.drop_front || cmd.drop_back) && !status.count_last)
                   || (cmd.append && status.count_full);
   assign ram_rd_back = cmd.start_prune || cmd.drop_back;
   assign ram_rd_addr = ram_rd_back ? wrap(head_in, count_in - CNT_W'(1)) : head_in;

   wpa_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      if (from_sample_ff) begin
         peak = value_ff;
      end else if (from_ram_ff) begin
         peak = rd_value;
      end else begin
         peak = front_ff;
      end
   end

   assign count_ext = (CNT_W + COUNT_OUT_W)'(count_ff);

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         window_ff    <= WINDOW_LENGTH_RESET;
         threshold_ff <= ALARM_THRESHOLD_RESET;
      end else begin
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable && (csr_index == REG_WINDOW_LENGTH)) begin
            window_ff <= csr_write_data;
         end
         if (csr_write_enable && (csr_index == REG_ALARM_THRESHOLD)) begin
            threshold_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         now_ff   <= req_data.sample_time;
         value_ff <= req_data.sample_value;
      end
      if (cmd.start_prune) begin
         front_ff <= rd_value;
      end
      if (cmd.append) begin
         from_sample_ff <= status.count_zero;
         from_ram_ff    <= status.count_full;
         ovf_ff         <= status.count_full;
      end
      if (cmd.finish) begin
         rsp_data_ff.window_peak     <= peak;
         rsp_data_ff.alarm           <= (peak > threshold_ff);
         rsp_data_ff.candidate_count <= count_ext[COUNT_OUT_W-1:0];
         rsp_data_ff.overflow        <= ovf_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: rtl/core/windowed_peak_alarm.sv
// Top level of the windowed peak alarm: sliding-window maximum over timed samples.
//
//   Channel   Ports                                      Direction  Carries
//   request   req_valid, req_stall, req_data             in         sample time and value
//   response  rsp_valid, rsp_stall, rsp_data             out        peak, alarm, count, overflow
//   csr       csr_write_enable, csr_index, csr_write_data  in       window length, threshold
//
// After a request is accepted, candidates are checked for expiry, then for pruning, one at a time
// as the memory has a single read port; then the sample is appended and the response registered.
// The block takes no new request until the response to the last one has been registered.
// Reset is synchronous; the queue is empty afterward and the memory needs no clearing.
// A stalled response holds in its register; the next request is accepted and then waits.
module windowed_peak_alarm #(
   parameter int DEPTH = wpa_pkg::DEPTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  wpa_pkg::wpa_req_type            req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output wpa_pkg::wpa_rsp_type            rsp_data,
   input  logic                            csr_write_enable,
   input  logic [wpa_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [wpa_pkg::CFG_W-1:0]       csr_write_data
);

   import wpa_pkg::*;

   wpa_cmd_type    cmd;
   wpa_status_type status;

   wpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   wpa_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_data         (req_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data)
   );

endmodule

FILE: rtl/core/wpa_checker.sv
// Port-level checker for the windowed peak alarm and its bind to the top level.
module wpa_checker #(
   parameter int DEPTH = wpa_pkg::DEPTH_DEFAULT
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input wpa_pkg::wpa_rsp_type rsp_data,
   input logic                 rsp_valid,
   input logic                 rsp_stall
);

   import wpa_pkg::*;

   localparam logic [COUNT_OUT_W-1:0] FULL_COUNT = COUNT_OUT_W'(DEPTH);
   localparam logic                   COUNT_WRAPS = (DEPTH >= (1 << COUNT_OUT_W));

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled response changed or vanished");

   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> !$rose(rsp_valid))
      else $error("response appeared one cycle after a request was accepted");

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !req_stall)
      else $error("block not ready for a request when a new response appeared");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.overflow) |-> (rsp_data.candidate_count == FULL_COUNT))
      else $error("overflow reported without a full candidate queue");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.candidate_count != '0) || COUNT_WRAPS))
      else $error("response reports an empty candidate queue");

endmodule

bind windowed_peak_alarm wpa_checker #(
   .DEPTH (DEPTH)
) u_wpa_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_data  (rsp_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall)
);

FILE: verif/wpa_checker.sv
// Checker for the windowed peak alarm: predicts every response and compares it field by field.
`timescale 1ns / 100ps

module wpa_scoreboard (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  wpa_pkg::wpa_req_type            req_data,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  wpa_pkg::wpa_rsp_type            rsp_data,
   input  logic                            csr_write_enable,
   input  logic [wpa_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [wpa_pkg::CFG_W-1:0]       csr_write_data,
   output int                              error_count,
   output int                              pending_count,
   output int                              results_checked,
   output int                              overflow_hits,
   output int                              alarm_hits
);

   import wpa_pkg::*;

   localparam int DEPTH = DEPTH_DEFAULT;

   logic [TIME_W-1:0]  cand_time  [DEPTH];
   logic [VALUE_W-1:0] cand_value [DEPTH];
   int                 cand_head;
   int                 cand_count;
   logic [CFG_W-1:0]   window_span;
   logic [CFG_W-1:0]   alarm_level;
   wpa_rsp_type        peak_expect_q [$];

   function automatic int slot_at(input int offset);
      return (cand_head + offset) % DEPTH;
   endfunction

   function automatic wpa_rsp_type advance_peak_window(input wpa_req_type s);
      wpa_rsp_type       r;
      logic [TIME_W-1:0] age;
      int                tail;
      r = '0;
      while (cand_count > 0) begin
         age = s.sample_time - cand_time[cand_head];
         if (age < TIME_W'(window_span)) break;
         cand_head = slot_at(1);
         cand_count--;
      end
      while (cand_count > 0 && cand_value[slot_at(cand_count - 1)] <= s.sample_value) begin
         cand_count--;
      end
      if (cand_count >= DEPTH) begin
         cand_head = slot_at(1);
         cand_count--;
         r.overflow = 1'b1;
      end
      tail = slot_at(cand_count);
      cand_time[tail]  = s.sample_time;
      cand_value[tail] = s.sample_value;
      cand_count++;
      r.window_peak     = cand_value[cand_head];
      r.alarm           = (r.window_peak > alarm_level);
      r.candidate_count = COUNT_OUT_W'(cand_count);
      return r;
   endfunction

   function automatic void compare_response(input wpa_rsp_type got, input wpa_rsp_type want);
      if (got.window_peak !== want.window_peak) begin
         $error("window_peak expected %0d actual %0d", want.window_peak, got.window_peak);
         error_count++;
      end
      if (got.alarm !== want.alarm) begin
         $error("alarm expected %0d actual %0d", want.alarm, got.alarm);
         error_count++;
      end
      if (got.candidate_count !== want.candidate_count) begin
         $error("candidate_count expected %0d actual %0d",
                want.candidate_count, got.candidate_count);
         error_count++;
      end
      if (got.overflow !== want.overflow) begin
         $error("overflow expected %0d actual %0d", want.overflow, got.overflow);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         window_span = WINDOW_LENGTH_RESET;
         alarm_level = ALARM_THRESHOLD_RESET;
         cand_head   = 0;
         cand_count  = 0;
         peak_expect_q.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               REG_WINDOW_LENGTH: begin
                  window_span = csr_write_data;
               end
               REG_ALARM_THRESHOLD: begin
                  alarm_level = csr_write_data;
               end
               default: begin
               end
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (peak_expect_q.size() == 0) begin
               $error("response with no request outstanding: window_peak %0d",
                      rsp_data.window_peak);
               error_count++;
            end else begin
               compare_response(rsp_data, peak_expect_q[0]);
               peak_expect_q.delete(0);
               results_checked++;
               if (rsp_data.overflow === 1'b1) overflow_hits++;
               if (rsp_data.alarm === 1'b1) alarm_hits++;
            end
         end
         if (req_valid && !req_stall) begin
            peak_expect_q = {peak_expect_q, advance_peak_window(req_data)};
         end
      end
      pending_count = peak_expect_q.size();
   end

endmodule

FILE: verif/tb_top.sv
// Testbench top for the windowed peak alarm: clock, reset, stimulus and the final verdict.
`timescale 1ns / 100ps

module tb_top;
   import wpa_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_2 = CSR_INDEX_W'(2);
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_3 = CSR_INDEX_W'(3);
   localparam int PHASE_ITEMS = 106;
   localparam int NUM_PHASES  = 8;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   wpa_req_type            req_data;
   logic                   rsp_valid;
   logic                   rsp_stall;
   wpa_rsp_type            rsp_data;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CFG_W-1:0]       csr_write_data;

   int error_count;
   int pending_count;
   int results_checked;
   int overflow_hits;
   int alarm_hits;

   int               idle_pct = 21;
   int               stall_pct = 21;
   bit               hold_pending = 1'b0;
   int               sent_count = 0;
   logic [TIME_W-1:0] sample_clock;
   logic [CFG_W-1:0] phase_window;
   logic [CFG_W-1:0] phase_threshold;

   windowed_peak_alarm u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   wpa_scoreboard u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .error_count      (error_count),
      .pending_count    (pending_count),
      .results_checked  (results_checked),
      .overflow_hits    (overflow_hits),
      .alarm_hits       (alarm_hits)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("TEST FAILED");
      $finish;
   end

   // The receiver stalls at random, and holds off for a long stretch when asked.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_pending) begin
            rsp_stall <= 1'b1;
            repeat (400) @(negedge clock);
            hold_pending = 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   task automatic send_sample(input logic [TIME_W-1:0] t, input logic [VALUE_W-1:0] v);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{sample_time: t, sample_value: v};
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      sent_count++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      wait (pending_count == 0);
      @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_reg_pair(input logic [CSR_INDEX_W-1:0] index_a,
                                 input logic [CFG_W-1:0]       data_a,
                                 input logic [CSR_INDEX_W-1:0] index_b,
                                 input logic [CFG_W-1:0]       data_b);
      csr_write_enable <= 1'b1;
      csr_index        <= index_a;
      csr_write_data   <= data_a;
      @(negedge clock);
      csr_index        <= index_b;
      csr_write_data   <= data_b;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Mostly forward-moving time with random values, plus strictly falling runs
   // that pile up candidates and occasional jumps to a random timestamp.
   task automatic run_random_phase(input int n_items, input logic [CFG_W-1:0] win);
      logic [TIME_W-1:0]  step_max;
      int                 run_left;
      logic [VALUE_W-1:0] run_value;
      logic [VALUE_W-1:0] v;
      step_max  = (TIME_W'(win) >> 2) + 1;
      run_left  = 0;
      run_value = '0;
      for (int i = 0; i < n_items; i++) begin
         if (run_left == 0 && $urandom_range(99) < 8) begin
            run_left  = $urandom_range(20, 90);
            run_value = 16'hFFFF - VALUE_W'($urandom_range(0, 200));
         end
         if (run_left > 0) begin
            run_left--;
            sample_clock += $urandom_range(0, 1);
            v = run_value;
            run_value -= VALUE_W'($urandom_range(1, 300));
         end else if ($urandom_range(99) < 4) begin
            sample_clock = $urandom;
            v = VALUE_W'($urandom);
         end else begin
            sample_clock += $urandom_range(0, step_max);
            v = ($urandom_range(3) == 0) ? VALUE_W'($urandom_range(0, 600)) : VALUE_W'($urandom);
         end
         send_sample(sample_clock, v);
      end
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_data         = '0;
      csr_write_enable = 1'b0;
      csr_index        = '0;
      csr_write_data   = '0;
      sample_clock     = '0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset settings: expiry at exactly the window age, ties pruned, values at both ends.
      send_sample(32'd0, 16'd0);
      send_sample(32'd10, 16'hFFFF);
      send_sample(32'd20, 16'd100);
      send_sample(32'd30, 16'd300);
      send_sample(32'd70, 16'd50);
      send_sample(32'd70, 16'd50);
      send_sample(32'd200, 16'd201);
      send_sample(32'd200, 16'd200);
      wait_drained();

      // A zero window keeps only the newest sample; a zero threshold alarms on any non-zero value.
      write_reg_pair(REG_WINDOW_LENGTH, 16'd0, REG_ALARM_THRESHOLD, 16'd0);
      send_sample(32'd300, 16'd5);
      send_sample(32'd300, 16'd5);
      send_sample(32'd301, 16'd0);
      wait_drained();

      // Widest window and top threshold, timestamps wrapping and going backwards.
      write_reg_pair(REG_WINDOW_LENGTH, 16'hFFFF, REG_ALARM_THRESHOLD, 16'hFFFF);
      send_sample(32'hFFFF_FFF0, 16'hFFFF);
      send_sample(32'hFFFF_FFFF, 16'd1000);
      send_sample(32'h0000_0005, 16'd999);
      send_sample(32'h0000_0001, 16'd998);
      send_sample(32'h8000_0000, 16'd7);
      send_sample(32'h7FFF_FFFF, 16'd6);
      wait_drained();

      // Writes to the unused indexes must leave both registers alone.
      write_reg_pair(REG_SPARE_2, 16'hFFFF, REG_SPARE_3, 16'h0000);
      send_sample(32'h7FFF_FFFF, 16'd4);
      send_sample(32'h8000_FFFD, 16'd3);

      for (int p = 0; p < NUM_PHASES; p++) begin
         wait_drained();
         phase_threshold = CFG_W'($urandom_range(0, 65535));
         case (p)
            0: phase_window = CFG_W'($urandom_range(20, 400));
            1: phase_window = 16'hFFFF;
            2: begin
               phase_window    = 16'd1;
               phase_threshold = 16'd0;
            end
            3: phase_window = CFG_W'($urandom);
            4: phase_window = CFG_W'($urandom_range(5, 100));
            5: begin
               phase_window    = 16'hFFFF;
               phase_threshold = 16'hFFFF;
            end
            6: phase_window = CFG_W'($urandom_range(60, 200));
            default: phase_window = CFG_W'($urandom_range(1000, 5000));
         endcase
         write_reg_pair(REG_WINDOW_LENGTH, phase_window, REG_ALARM_THRESHOLD, phase_threshold);
         idle_pct     = (p == 4) ? 0 : 21;
         stall_pct    = (p == 4) ? 0 : 21;
         hold_pending = (p == 2);
         sample_clock = $urandom;
         run_random_phase(PHASE_ITEMS, phase_window);
      end

      req_valid <= 1'b0;
      wait (pending_count == 0);
      repeat (200) @(posedge clock);
      $display("Sent %0d samples over %0d register settings; checked %0d responses.",
               sent_count, NUM_PHASES + 4, results_checked);
      $display("Responses with overflow: %0d, with alarm: %0d.", overflow_hits, alarm_hits);
      if (error_count == 0 && pending_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/core/wpa_pkg.sv
rtl/core/wpa_ram.sv
rtl/core/wpa_ctrl.sv
rtl/core/wpa_datapath.sv
rtl/core/windowed_peak_alarm.sv
rtl/core/wpa_checker.sv
verif/wpa_checker.sv
verif/tb_top.sv
